// ===== rtl/core/p448_pkg.sv =====
// Package for the GF(2^448 - 2^224 - 1) multiply core.
// Holds limb widths, the sequencer state and operation codes, and the control struct.
// No dependencies.
package p448_pkg;

  localparam int LimbBits  = 56;
  localparam int InBits    = 59;
  localparam int NumLimbs  = 8;
  localparam int IdxBits   = 3;
  localparam int NumCols   = 15;
  localparam int ColIdxBits = 4;
  localparam int ColBits   = 128;
  localparam int PartBits  = 30;
  localparam int ProdBits  = 2 * PartBits;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_FOLD1,
    ST_FOLD2,
    ST_CARRY,
    ST_WRAP,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_MUL,
    OP_ACC,
    OP_FOLD1,
    OP_FOLD2,
    OP_CARRY,
    OP_WRAP
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [IdxBits-1:0]    a_addr;
    logic [IdxBits-1:0]    b_addr;
    logic [1:0]            part;
    logic [ColIdxBits-1:0] sel;
    logic                  emit;
    logic [IdxBits-1:0]    emit_idx;
  } ctrl_t;

endpackage

// ===== rtl/core/p448_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module p448_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/p448_ctrl.sv =====
// Sequencer of the multiply core: product loop, fold, carry passes and limb output.
// Depends on p448_pkg.
module p448_ctrl
  import p448_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               result_valid,
  input  logic               result_stall,
  output logic               busy,
  output ctrl_t              ctrl
);

  state_t             state, state_next;
  logic [IdxBits-1:0] i, j, k;
  logic [1:0]         q;
  logic               pass;
  logic               out_free;

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_CLEAR;
      ST_CLEAR: state_next = ST_READ;
      ST_READ:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_ACC;
      ST_ACC: begin
        if (q != 2'd3) state_next = ST_MUL;
        else if (i == IdxBits'(NumLimbs - 1) && j == IdxBits'(NumLimbs - 1))
          state_next = ST_FOLD1;
        else state_next = ST_READ;
      end
      ST_FOLD1: state_next = ST_FOLD2;
      ST_FOLD2: state_next = ST_CARRY;
      ST_CARRY: if (k == IdxBits'(NumLimbs - 1)) state_next = ST_WRAP;
      ST_WRAP:  state_next = pass ? ST_EMIT : ST_CARRY;
      ST_EMIT:  if (out_free && k == IdxBits'(NumLimbs - 1)) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.op       = OP_NONE;
    ctrl.a_addr   = i;
    ctrl.b_addr   = j;
    ctrl.part     = q;
    ctrl.sel      = {1'b0, i} + {1'b0, j};
    ctrl.emit_idx = k;
    unique case (state)
      ST_CLEAR: ctrl.op = OP_CLEAR;
      ST_MUL:   ctrl.op = OP_MUL;
      ST_ACC:   ctrl.op = OP_ACC;
      ST_FOLD1: ctrl.op = OP_FOLD1;
      ST_FOLD2: ctrl.op = OP_FOLD2;
      ST_CARRY: begin
        ctrl.op  = OP_CARRY;
        ctrl.sel = {1'b0, k};
      end
      ST_WRAP:  ctrl.op = OP_WRAP;
      ST_EMIT: begin
        ctrl.sel  = {1'b0, k};
        ctrl.emit = out_free;
      end
      default:  ctrl.op = OP_NONE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      q     <= '0;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: begin
          i <= '0;
          j <= '0;
          q <= '0;
        end
        ST_ACC: begin
          q <= q + 2'd1;
          if (q == 2'd3) begin
            j <= j + 1'b1;
            if (j == IdxBits'(NumLimbs - 1)) i <= i + 1'b1;
          end
        end
        ST_FOLD2: begin
          k    <= '0;
          pass <= 1'b0;
        end
        ST_CARRY: k <= k + 1'b1;
        ST_WRAP:  pass <= 1'b1;
        ST_EMIT:  if (out_free) k <= k + 1'b1;
        default:  ;
      endcase
    end
  end

endmodule

// ===== rtl/core/p448_dp.sv =====
// Datapath: split multiplier, fifteen column accumulators, fold and carry chain.
// Depends on p448_pkg; driven by p448_ctrl through ctrl_t.
module p448_dp
  import p448_pkg::*;
(
  input  logic                clk,
  input  ctrl_t               ctrl,
  input  logic [InBits-1:0]   a_word,
  input  logic [InBits-1:0]   b_word,
  output logic [LimbBits-1:0] limb_out
);

  logic [ColBits-1:0]  col [NumCols];
  logic [ProdBits-1:0] prod;
  logic [PartBits-1:0] a_part, b_part;
  logic [1:0]          part_q;
  logic [ColBits-1:0]  carry;
  logic [ColBits-1:0]  sel_col;
  logic [ColBits-1:0]  csum;
  logic [ColBits-1:0]  shifted;

  // Each 59-bit operand splits into a 30-bit low half and a 29-bit high half.
  assign a_part = ctrl.part[1] ? PartBits'(a_word[InBits-1:PartBits]) : a_word[PartBits-1:0];
  assign b_part = ctrl.part[0] ? PartBits'(b_word[InBits-1:PartBits]) : b_word[PartBits-1:0];

  assign sel_col = col[ctrl.sel];
  assign csum    = sel_col + carry;
  assign shifted = ColBits'(prod) << (PartBits * (32'(part_q[1]) + 32'(part_q[0])));
  assign limb_out = sel_col[LimbBits-1:0];

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_CLEAR: begin
        for (int n = 0; n < NumCols; n++) col[n] <= '0;
      end
      OP_MUL: begin
        prod   <= ProdBits'(a_part) * ProdBits'(b_part);
        part_q <= ctrl.part;
      end
      OP_ACC: col[ctrl.sel] <= sel_col + shifted;
      OP_FOLD1: begin
        for (int n = 0; n < 3; n++) begin
          col[n]     <= col[n] + col[n+8];
          col[n+4]   <= col[n+4] + col[n+8];
        end
        col[3] <= col[3] + col[11];
        col[7] <= col[7] + col[11];
        carry  <= '0;
      end
      OP_FOLD2: begin
        // Columns twelve to fourteen fold once into the low half, twice into the high half.
        for (int n = 0; n < 3; n++) begin
          col[n]   <= col[n] + col[n+12];
          col[n+4] <= col[n+4] + (col[n+12] << 1);
        end
      end
      OP_CARRY: begin
        col[ctrl.sel] <= ColBits'(csum[LimbBits-1:0]);
        carry         <= csum >> LimbBits;
      end
      OP_WRAP: begin
        col[0] <= col[0] + carry;
        col[4] <= col[4] + carry;
        carry  <= '0;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/p448_modular_multiply_core.sv =====
// Top level of the GF(2^448 - 2^224 - 1) multiply core.
// Depends on p448_pkg, p448_ram, p448_ctrl and p448_dp.
//
// Usage:
//   The load channel (load_valid, load_stall) carries one limb pair per transfer:
//   limb_index, a_limb, b_limb. Pairs 0 to 7 are written into two 8-entry operand
//   RAMs; the transfer with limb_index 7 starts the multiply.
//   The result channel (result_valid, result_stall) then delivers eight limbs,
//   out_index 0 to 7, each below 2^56; last marks the limb with index 7.
// Timing:
//   Loads 0 to 6 are taken whenever load_stall is low. The product runs on one
//   30x30 multiplier, four partial products per limb pair, each through a multiply
//   state then an accumulate state, after one RAM read. Fold runs in FOLD1 then
//   FOLD2, then the two carry passes each run over the eight columns and close
//   with a wrap step; then the eight limbs leave at one per cycle when not stalled.
//   load_stall is high from the starting transfer until the last limb enters
//   the output register. A stalled result register holds its limb and the
//   sequencer waits; loads are taken again while the final limb still waits.
// Reset:
//   rst is synchronous; it idles the sequencer and empties the output register.
//   Operand RAMs are not cleared.
module p448_modular_multiply_core
  import p448_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  output logic                load_stall,
  input  logic [IdxBits-1:0]  limb_index,
  input  logic [InBits-1:0]   a_limb,
  input  logic [InBits-1:0]   b_limb,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [IdxBits-1:0]  out_index,
  output logic [LimbBits-1:0] product_limb,
  output logic                last
);

  logic                accept;
  logic                busy;
  ctrl_t               ctrl;
  logic [InBits-1:0]   a_word, b_word;
  logic [LimbBits-1:0] limb_out;

  assign load_stall = busy;
  assign accept     = load_valid && !load_stall;

  p448_ram #(.Width(InBits), .Depth(NumLimbs)) u_ram_a (
    .clk   (clk),
    .we    (accept),
    .waddr (limb_index),
    .wdata (a_limb),
    .raddr (ctrl.a_addr),
    .rdata (a_word)
  );

  p448_ram #(.Width(InBits), .Depth(NumLimbs)) u_ram_b (
    .clk   (clk),
    .we    (accept),
    .waddr (limb_index),
    .wdata (b_limb),
    .raddr (ctrl.b_addr),
    .rdata (b_word)
  );

  p448_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (accept && limb_index == IdxBits'(NumLimbs - 1)),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .busy         (busy),
    .ctrl         (ctrl)
  );

  p448_dp u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .a_word   (a_word),
    .b_word   (b_word),
    .limb_out (limb_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_index    <= ctrl.emit_idx;
      product_limb <= limb_out;
      last         <= (ctrl.emit_idx == IdxBits'(NumLimbs - 1));
    end
  end

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept && limb_index == IdxBits'(NumLimbs - 1) |=> load_stall)
    else $error("multiply start did not block further loads");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    accept && limb_index != IdxBits'(NumLimbs - 1) |=> !load_stall)
    else $error("plain load blocked the load channel");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> out_index == IdxBits'(NumLimbs - 1))
    else $error("last flag on a limb other than the top one");
`endif

endmodule
